@@ hdl/mpm_pkg.sv @@
// Shared types and constants of the memory pressure monitor.
package mpm_pkg;

   localparam int BYTE_W  = 21;
   localparam int TIME_W  = 32;
   localparam int Q_W     = 17;
   localparam int HOLD_W  = 20;
   localparam int CD_W    = 20;
   localparam int PCT_W   = 7;
   localparam int LEVEL_W = 2;
   localparam int NUM_W   = BYTE_W + 28;
   localparam int DEN_W   = BYTE_W + 16;

   localparam logic [Q_W-1:0]   Q_ONE    = 17'h10000;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam logic [1:0] FUNC_SAMPLE      = 2'd0;
   localparam logic [1:0] FUNC_RESET_PEAKS = 2'd1;
   localparam logic [1:0] FUNC_CONSUME     = 2'd2;
   localparam logic [1:0] FUNC_NONE        = 2'd3;

   localparam logic [2:0] OP_H1   = 3'd0;
   localparam logic [2:0] OP_H2   = 3'd1;
   localparam logic [2:0] OP_G1   = 3'd2;
   localparam logic [2:0] OP_G2   = 3'd3;
   localparam logic [2:0] OP_PEN  = 3'd4;
   localparam logic [2:0] OP_FRAG = 3'd5;
   localparam logic [2:0] OP_CD   = 3'd6;

   localparam logic [2:0] REG_FREE_LIMITS  = 3'd0;
   localparam logic [2:0] REG_FRAG_LIMITS  = 3'd1;
   localparam logic [2:0] REG_TLS_FREE     = 3'd2;
   localparam logic [2:0] REG_TLS_CONTIG   = 3'd3;
   localparam logic [2:0] REG_PENALTY      = 3'd4;
   localparam logic [2:0] REG_HOLD         = 3'd5;
   localparam logic [2:0] REG_COND_LIMITS  = 3'd6;
   localparam logic [2:0] REG_COOL_LIMITS  = 3'd7;

   typedef struct packed {
      logic [1:0]        func;
      logic [BYTE_W-1:0] free_bytes;
      logic [BYTE_W-1:0] largest_block;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [PCT_W-1:0]   health_pct;
      logic [LEVEL_W-1:0] pressure_level;
      logic               condition_request;
      logic [BYTE_W-1:0]  min_free;
      logic [BYTE_W-1:0]  min_largest;
   } rsp_type;

   typedef struct packed {
      logic [62:0] free_level_limits;
      logic [47:0] frag_level_limits;
      logic [20:0] tls_free_minimum;
      logic [20:0] tls_contig_minimum;
      logic [15:0] frag_penalty_scale;
      logic [19:0] deescalate_hold_ms;
      logic [34:0] condition_limits;
      logic [59:0] cooldown_limits;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       marks;
      logic       div_start;
      logic [2:0] div_sel;
      logic       mul;
      logic       pct;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic       div_busy;
      logic       div_done;
      logic [1:0] func;
   } stat_type;

endpackage

@@ hdl/memory_pressure_monitor.sv @@
// Top level of the memory pressure monitor: register file, controller and datapath.
// A sample runs seven divisions one after another through one shared divider, then the
// product, the percentage and the commit. A reset-peaks item needs five divisions; consume
// and no-op items go straight from the watermarks to the commit. The block is ready for the
// next transfer in the cycle after the commit; the commit stalls while an earlier result is
// still waiting to be taken. Synchronous active-high reset clears control, configuration and
// monitor state; health reads 100 and the penalty scale 1.0.
module memory_pressure_monitor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpm_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [5:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   mpm_pkg::cfg_type  cfg_ff, cfg_in;
   mpm_pkg::cmd_type  cmd;
   mpm_pkg::stat_type stat;
   logic              wr_en;
   logic [2:0]        reg_idx;

   // Registers sit at eight-byte strides; the write lands in the access phase.
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[5:3];

   // Reset clears every register except the penalty scale, which starts at 1.0.
   always_comb begin
      cfg_in = cfg_ff;
      if (reset) begin
         cfg_in = '0;
         cfg_in.frag_penalty_scale = 16'd4096;
      end else if (wr_en) begin
         unique case (reg_idx)
            mpm_pkg::REG_FREE_LIMITS: cfg_in.free_level_limits  = pwdata[62:0];
            mpm_pkg::REG_FRAG_LIMITS: cfg_in.frag_level_limits  = pwdata[47:0];
            mpm_pkg::REG_TLS_FREE:    cfg_in.tls_free_minimum   = pwdata[20:0];
            mpm_pkg::REG_TLS_CONTIG:  cfg_in.tls_contig_minimum = pwdata[20:0];
            mpm_pkg::REG_PENALTY:     cfg_in.frag_penalty_scale = pwdata[15:0];
            mpm_pkg::REG_HOLD:        cfg_in.deescalate_hold_ms = pwdata[19:0];
            mpm_pkg::REG_COND_LIMITS: cfg_in.condition_limits   = pwdata[34:0];
            default:                  cfg_in.cooldown_limits    = pwdata[59:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         mpm_pkg::REG_FREE_LIMITS: prdata = 64'(cfg_ff.free_level_limits);
         mpm_pkg::REG_FRAG_LIMITS: prdata = 64'(cfg_ff.frag_level_limits);
         mpm_pkg::REG_TLS_FREE:    prdata = 64'(cfg_ff.tls_free_minimum);
         mpm_pkg::REG_TLS_CONTIG:  prdata = 64'(cfg_ff.tls_contig_minimum);
         mpm_pkg::REG_PENALTY:     prdata = 64'(cfg_ff.frag_penalty_scale);
         mpm_pkg::REG_HOLD:        prdata = 64'(cfg_ff.deescalate_hold_ms);
         mpm_pkg::REG_COND_LIMITS: prdata = 64'(cfg_ff.condition_limits);
         default:                  prdata = 64'(cfg_ff.cooldown_limits);
      endcase
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   // The controller walks a sample or reset-peaks item through watermarks, divisions, product, percentage and commit.
   mpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the monitor state and the output register.
   mpm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // A transfer in makes the block busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   // A division only starts on an idle divider.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider restarted while busy");

   // A result is only committed when the output slot is free.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten");

   // A new result appears only after a commit.
   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result without commit");
endmodule

@@ hdl/mpm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mpm_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   shifted, diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;
endmodule

@@ hdl/mpm_ctrl.sv @@
// Sequencing state machine of the memory pressure monitor.
module mpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mpm_pkg::stat_type stat,
   output mpm_pkg::cmd_type  cmd
);
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MARKS  = 7'b0000010,
      ST_DSTART = 7'b0000100,
      ST_DWAIT  = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_PCT    = 7'b0100000,
      ST_COMMIT = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in, last_op;
   logic       valid_ff, valid_in;
   logic       out_free;

   always_comb begin
      out_free = !valid_ff || rsp_ready;
      last_op  = (stat.func == mpm_pkg::FUNC_RESET_PEAKS) ? mpm_pkg::OP_PEN : mpm_pkg::OP_CD;
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.div_sel = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MARKS;
            end
         end
         ST_MARKS: begin
            cmd.marks = 1'b1;
            op_in     = mpm_pkg::OP_H1;
            if (stat.func == mpm_pkg::FUNC_SAMPLE || stat.func == mpm_pkg::FUNC_RESET_PEAKS) begin
               state_in = ST_DSTART;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (stat.div_done) begin
               if (op_ff == last_op) begin
                  state_in = ST_MUL;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_DSTART;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PCT;
         end
         ST_PCT: begin
            cmd.pct  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= mpm_pkg::OP_H1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
endmodule

@@ hdl/mpm_dp.sv @@
// Datapath: watermarks, ratio divisions, health, level and request state.
module mpm_dp (
   input  logic              clock,
   input  logic              reset,
   input  mpm_pkg::req_type  req_data,
   input  mpm_pkg::cfg_type  cfg,
   input  mpm_pkg::cmd_type  cmd,
   output mpm_pkg::stat_type stat,
   output mpm_pkg::rsp_type  rsp_data
);
   localparam int BW = mpm_pkg::BYTE_W;
   localparam int TW = mpm_pkg::TIME_W;
   localparam int QW = mpm_pkg::Q_W;
   localparam int NW = mpm_pkg::NUM_W;
   localparam int DW = mpm_pkg::DEN_W;

   mpm_pkg::req_type in_ff;
   mpm_pkg::rsp_type rsp_ff, rsp_in;

   logic [BW-1:0] peak_free_ff, peak_free_in, peak_lg_ff, peak_lg_in;
   logic [BW-1:0] low_free_ff, low_free_in, low_lg_ff, low_lg_in;
   logic [6:0]    health_ff, health_in;
   logic [1:0]    level_ff, level_in, esc_ff, esc_in, nl;
   logic [TW-1:0] lct_ff, lct_in, rqt_ff, rqt_in;
   logic          pend_ff, pend_in, req_out;

   logic [DW-1:0]   frs_ff;
   logic [40:0]     bl_ff;
   logic [2:0]      op_ff;
   logic [QW-1:0]   h1_ff, h2_ff, g1_ff, g2_ff, pen_ff, frag_ff, qsat, hmin, gmin;
   logic [20:0]     cd_ff, cd_fin;
   logic [2*QW-1:0] prod_ff;
   logic [39:0]     scaled;
   logic [7:0]      pct_raw;
   logic [6:0]      pct_ff;

   logic [NW-1:0] div_num, quot;
   logic [DW-1:0] div_den;
   logic          div_busy, div_done;

   logic [BW-1:0] fr, lg, pf, pl;
   logic [TW-1:0] now;
   logic [1:0]    cnt_up;
   logic [6:0]    trig, clr;
   logic [20:0]   thr;
   logic [19:0]   cd_base, cd_min, cd_max;
   logic          gate_on;

   assign fr      = in_ff.free_bytes;
   assign lg      = in_ff.largest_block;
   assign now     = in_ff.now_ms;
   assign trig    = cfg.condition_limits[6:0];
   assign clr     = cfg.condition_limits[13:7];
   assign thr     = cfg.condition_limits[34:14];
   assign cd_base = cfg.cooldown_limits[19:0];
   assign cd_min  = cfg.cooldown_limits[39:20];
   assign cd_max  = cfg.cooldown_limits[59:40];
   assign gate_on = (cfg.tls_free_minimum != '0) && (cfg.tls_contig_minimum != '0);

   always_comb begin
      unique case (cmd.div_sel)
         mpm_pkg::OP_H1: begin
            div_num = NW'({fr, 16'b0});
            div_den = DW'(peak_free_ff);
         end
         mpm_pkg::OP_H2: begin
            div_num = NW'({lg, 16'b0});
            div_den = DW'(peak_lg_ff);
         end
         mpm_pkg::OP_G1: begin
            div_num = NW'({fr, 16'b0});
            div_den = DW'(cfg.tls_free_minimum);
         end
         mpm_pkg::OP_G2: begin
            div_num = NW'({lg, 16'b0});
            div_den = DW'(cfg.tls_contig_minimum);
         end
         mpm_pkg::OP_PEN: begin
            div_num = NW'({lg, 28'b0});
            div_den = frs_ff;
         end
         mpm_pkg::OP_FRAG: begin
            div_num = NW'({lg, 16'b0});
            div_den = DW'(fr);
         end
         default: begin
            div_num = NW'(bl_ff);
            div_den = DW'(cfg.tls_contig_minimum);
         end
      endcase
   end

   mpm_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   assign qsat = (quot > NW'(mpm_pkg::Q_ONE)) ? mpm_pkg::Q_ONE : quot[QW-1:0];

   always_comb begin
      gmin   = (g2_ff < g1_ff) ? g2_ff : g1_ff;
      hmin   = (h2_ff < h1_ff) ? h2_ff : h1_ff;
      if (gate_on && gmin < hmin) hmin = gmin;
      scaled  = 40'(prod_ff) * 40'd100 + 40'h80000000;
      pct_raw = scaled[39:32];
      cd_fin  = cd_ff;
      if (cfg.tls_contig_minimum != '0) begin
         if (cd_fin < 21'(cd_min)) cd_fin = 21'(cd_min);
         if (cd_fin > 21'(cd_max)) cd_fin = 21'(cd_max);
      end
   end

   // Pressure level from the free bytes and the fragmentation ratio.
   always_comb begin
      priority if (21'(fr) < cfg.free_level_limits[62:42] ||
                   frag_ff < QW'(cfg.frag_level_limits[47:32])) begin
         nl = 2'd3;
      end else if (21'(fr) < cfg.free_level_limits[41:21] ||
                   frag_ff < QW'(cfg.frag_level_limits[31:16])) begin
         nl = 2'd2;
      end else if (21'(fr) < cfg.free_level_limits[20:0] ||
                   frag_ff < QW'(cfg.frag_level_limits[15:0])) begin
         nl = 2'd1;
      end else begin
         nl = 2'd0;
      end
   end

   always_comb begin
      peak_free_in = peak_free_ff;
      peak_lg_in   = peak_lg_ff;
      low_free_in  = low_free_ff;
      low_lg_in    = low_lg_ff;
      health_in    = health_ff;
      level_in     = level_ff;
      esc_in       = esc_ff;
      lct_in       = lct_ff;
      rqt_in       = rqt_ff;
      pend_in      = pend_ff;
      req_out      = pend_ff;
      pf           = peak_free_ff;
      pl           = peak_lg_ff;
      cnt_up       = (esc_ff == 2'd3) ? esc_ff : esc_ff + 1'b1;
      rsp_in       = rsp_ff;
      if (cmd.marks) begin
         if (in_ff.func == mpm_pkg::FUNC_SAMPLE) begin
            if (pf == '0 || pl == '0) begin
               pf = fr;
               pl = lg;
            end
            if (fr > pf) pf = fr;
            if (lg > pl) pl = lg;
            peak_free_in = pf;
            peak_lg_in   = pl;
            if (low_free_ff == '0 || fr < low_free_ff) low_free_in = fr;
            if (low_lg_ff == '0 || lg < low_lg_ff) low_lg_in = lg;
         end else if (in_ff.func == mpm_pkg::FUNC_RESET_PEAKS) begin
            peak_free_in = fr;
            peak_lg_in   = lg;
         end
      end
      if (cmd.commit) begin
         unique case (in_ff.func)
            mpm_pkg::FUNC_SAMPLE: begin
               health_in = pct_ff;
               if (nl != level_ff) begin
                  if (nl > level_ff) begin
                     esc_in = cnt_up;
                     if (cnt_up >= ((nl == 2'd3) ? 2'd1 : 2'd2)) begin
                        level_in = nl;
                        lct_in   = now;
                        esc_in   = '0;
                     end
                  end else if ((now - lct_ff) >= TW'(cfg.deescalate_hold_ms)) begin
                     level_in = nl;
                     lct_in   = now;
                     esc_in   = '0;
                  end
               end else begin
                  esc_in = '0;
               end
               if (!pend_ff) begin
                  if (pct_ff <= trig && 21'(lg) < thr &&
                      (rqt_ff == '0 || (now - rqt_ff) >= TW'(cd_fin))) begin
                     pend_in = 1'b1;
                  end
               end else if (pct_ff >= clr && 21'(lg) >= thr) begin
                  pend_in = 1'b0;
               end
               req_out = pend_in;
            end
            mpm_pkg::FUNC_RESET_PEAKS: begin
               health_in = pct_ff;
               pend_in   = 1'b0;
               rqt_in    = now;
               req_out   = 1'b0;
            end
            mpm_pkg::FUNC_CONSUME: begin
               pend_in = 1'b0;
               req_out = pend_ff;
            end
            default: req_out = pend_ff;
         endcase
         rsp_in.health_pct        = health_in;
         rsp_in.pressure_level    = level_in;
         rsp_in.condition_request = req_out;
         rsp_in.min_free          = low_free_in;
         rsp_in.min_largest       = low_lg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req_data;
      if (cmd.marks) begin
         frs_ff <= DW'(fr) * DW'(cfg.frag_penalty_scale);
         bl_ff  <= 41'(cd_base) * 41'(lg);
      end
      if (cmd.div_start) op_ff <= cmd.div_sel;
      if (div_done) begin
         unique case (op_ff)
            mpm_pkg::OP_H1:   h1_ff <= (peak_free_ff == '0) ? '0 : qsat;
            mpm_pkg::OP_H2:   h2_ff <= (peak_lg_ff == '0) ? '0 : qsat;
            mpm_pkg::OP_G1:   g1_ff <= qsat;
            mpm_pkg::OP_G2:   g2_ff <= qsat;
            mpm_pkg::OP_PEN: begin
               if (fr == '0) pen_ff <= '0;
               else if (cfg.frag_penalty_scale == '0) pen_ff <= mpm_pkg::Q_ONE;
               else pen_ff <= qsat;
            end
            mpm_pkg::OP_FRAG: frag_ff <= (fr == '0) ? '0 : qsat;
            default: begin
               if (cfg.tls_contig_minimum == '0) cd_ff <= 21'(cd_base);
               else cd_ff <= (quot > NW'(21'h100000)) ? 21'h100000 : quot[20:0];
            end
         endcase
      end
      if (cmd.mul) prod_ff <= hmin * pen_ff;
      if (cmd.pct) pct_ff <= (pct_raw > 8'(mpm_pkg::PCT_FULL)) ? mpm_pkg::PCT_FULL : pct_raw[6:0];
      rsp_ff <= rsp_in;
      if (reset) begin
         peak_free_ff <= '0;
         peak_lg_ff   <= '0;
         low_free_ff  <= '0;
         low_lg_ff    <= '0;
         health_ff    <= mpm_pkg::PCT_FULL;
         level_ff     <= '0;
         esc_ff       <= '0;
         lct_ff       <= '0;
         rqt_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         peak_free_ff <= peak_free_in;
         peak_lg_ff   <= peak_lg_in;
         low_free_ff  <= low_free_in;
         low_lg_ff    <= low_lg_in;
         health_ff    <= health_in;
         level_ff     <= level_in;
         esc_ff       <= esc_in;
         lct_ff       <= lct_in;
         rqt_ff       <= rqt_in;
         pend_ff      <= pend_in;
      end
   end

   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;
   assign stat.func     = in_ff.func;
   assign rsp_data      = rsp_ff;
endmodule
